// File: rtl/column_handwriting_features_top_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef COLUMN_HANDWRITING_FEATURES_TOP_MACROS_SVH
`define COLUMN_HANDWRITING_FEATURES_TOP_MACROS_SVH

// Implication check under synchronous reset
`define CHF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check
`define CHF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/chf_pkg.sv
// Types and constants for the column feature block
package chf_pkg;
    localparam int MaxRows = 64;
    localparam logic [15:0] GradHalf = 16'd32768;
    localparam logic [15:0] GradDiag = 16'd46341;
    localparam logic [6:0] RowsReset = 7'd64;

    typedef struct packed {
        logic [63:0] column_pixels;
        logic        last_column;
    } t_in_item;

    typedef struct packed {
        logic [16:0] white_fraction;
        logic [20:0] mean_row;
        logic [20:0] second_moment;
        logic [5:0]  top_black_row;
        logic [5:0]  bottom_black_row;
        logic [15:0] top_gradient;
        logic [15:0] bottom_gradient;
        logic [5:0]  transitions;
        logic [16:0] black_ratio;
        logic        last_result;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SPAN, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [40:0] dividend;
        logic [12:0] divisor;
    } t_div_req;

    function automatic logic [15:0] grad(input logic a, input logic b);
        logic [1:0] n;
        n = {1'b0, a} + {1'b0, b};
        unique case (n)
            2'd0:    grad = 16'd0;
            2'd1:    grad = GradHalf;
            default: grad = GradDiag;
        endcase
    endfunction
endpackage

// File: rtl/column_handwriting_features_top.sv
// Column feature extractor: top level with sequencer
// Usage: columns enter on i_in_valid/o_in_ready, one 64-bit column and an
// end-of-image flag per item. A column is held until its right neighbour
// arrives; then one result item leaves on o_out_valid/i_out_ready. A column
// flagged last yields the held column's result, if one is held, and its own.
// Each result takes a row scan (one row a cycle), a span scan of up to R
// rows and four divisions on one shared serial divider; the block takes
// no item while busy.
// o_out_item sits in an output register; a stalled receiver holds it and the
// block, and the next column is not taken until the result is delivered.
// i_cfg_we writes rows_in_use at any edge; write it only while idle.
// Reset (synchronous, active low) clears held columns and sets rows to 64.
`include "column_handwriting_features_top_macros.svh"
module column_handwriting_features_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  chf_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output chf_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_wdata
);
    import chf_pkg::*;

    t_state r_state, n_state;
    logic [6:0]  r_rows_cfg;
    logic [63:0] r_left, r_held, r_new, r_col, r_lft, r_rgt;
    logic        r_have, r_newlast, r_pend, r_last;
    logic [6:0]  r_r;
    logic [6:0]  r_rows;
    logic [6:0]  r_cnt;
    logic [18:0] r_sum;
    logic [24:0] r_sumsq;
    logic [5:0]  r_top, r_bot;
    logic        r_found, r_prev;
    logic [5:0]  r_trans;
    logic [6:0]  r_black;
    logic [1:0]  r_dsel;
    logic        r_dwait;
    t_out_item   r_out;
    logic        r_ovalid;
    t_div_req    w_req;
    logic        w_done;
    logic [40:0] w_quot;
    logic [6:0]  w_rows;
    logic        w_pix, w_last_row;
    logic [12:0] w_rsq;
    logic [63:0] w_mask;

    always_comb begin
        w_rows = (r_rows_cfg == 7'd0) ? 7'd1 :
                 (r_rows_cfg > 7'(MaxRows)) ? 7'(MaxRows) : r_rows_cfg;
    end
    assign w_mask = (r_rows >= 7'd64) ? '1 : ((64'd1 << r_rows[5:0]) - 64'd1);
    assign w_pix = r_col[r_r[5:0]];
    assign w_rsq = 13'(r_rows) * 13'(r_rows);

    chf_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_last_row = 1'b0;
        w_req = '0;
        unique case (r_state)
            ST_IDLE: if (r_pend && !r_ovalid) n_state = ST_SCAN;
            ST_SCAN: begin
                w_last_row = (r_r == r_rows - 7'd1);
                if (w_last_row) n_state = ST_SPAN;
            end
            ST_SPAN: if (r_r > {1'b0, r_bot}) n_state = ST_DIV;
            ST_DIV: begin
                w_req.start = !r_dwait;
                unique case (r_dsel)
                    2'd0: begin
                        w_req.dividend = 41'({r_cnt, 16'd0});
                        w_req.divisor = 13'(r_rows);
                    end
                    2'd1: begin
                        w_req.dividend = 41'({r_sum, 16'd0});
                        w_req.divisor = 13'(r_rows);
                    end
                    2'd2: begin
                        w_req.dividend = {r_sumsq, 16'd0};
                        w_req.divisor = w_rsq;
                    end
                    default: begin
                        w_req.dividend = 41'({r_black + 7'd1, 16'd0});
                        w_req.divisor = 13'({1'b0, r_bot} - {1'b0, r_top} + 7'd1);
                    end
                endcase
                if (w_done && r_dsel == 2'd3) n_state = ST_OUT;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE) && !r_pend && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= RowsReset;
            r_have <= 1'b0;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
            r_left <= '0;
            r_held <= '0;
        end else begin
            if (i_cfg_we) r_rows_cfg <= i_cfg_wdata;
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_new <= i_in_item.column_pixels;
                        r_newlast <= i_in_item.last_column;
                        r_pend <= r_have || i_in_item.last_column;
                        if (!r_have && !i_in_item.last_column) begin
                            r_held <= i_in_item.column_pixels;
                            r_have <= 1'b1;
                        end
                    end else if (r_pend && !r_ovalid) begin
                        // pick the column to work on: held first, then a last one
                        r_rows <= w_rows;
                        r_r <= '0; r_cnt <= '0; r_sum <= '0; r_sumsq <= '0;
                        r_found <= 1'b0; r_top <= '0;
                        r_bot <= 6'(w_rows - 7'd1);
                        if (r_have) begin
                            r_col <= r_held; r_lft <= r_left; r_rgt <= r_new;
                            r_last <= 1'b0;
                        end else begin
                            r_col <= r_new; r_lft <= r_left; r_rgt <= '0;
                            r_last <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_r == 7'd0) begin
                        r_col <= r_col & w_mask;
                        r_lft <= r_lft & w_mask;
                        r_rgt <= r_rgt & w_mask;
                    end
                    if (w_pix && r_r < r_rows) begin
                        r_cnt <= r_cnt + 7'd1;
                        r_sum <= r_sum + 19'(r_r);
                        r_sumsq <= r_sumsq + 25'(12'(r_r[5:0]) * 12'(r_r[5:0]));
                    end else begin
                        if (!r_found) begin
                            r_top <= r_r[5:0];
                            r_found <= 1'b1;
                        end
                        r_bot <= r_r[5:0];
                    end
                    if (w_last_row) begin
                        r_r <= 7'(r_found ? r_top : (w_pix ? 6'd0 : r_r[5:0])) + 7'd1;
                        r_trans <= '0; r_black <= '0; r_prev <= 1'b0;
                    end else begin
                        r_r <= r_r + 7'd1;
                    end
                end
                ST_SPAN: begin
                    if (r_r <= {1'b0, r_bot}) begin
                        if (w_pix != r_prev) r_trans <= r_trans + 6'd1;
                        r_prev <= w_pix;
                        if (!w_pix) r_black <= r_black + 7'd1;
                        r_r <= r_r + 7'd1;
                    end else begin
                        r_dsel <= 2'd0;
                        r_dwait <= 1'b0;
                    end
                end
                ST_DIV: begin
                    if (!r_dwait) r_dwait <= 1'b1;
                    if (w_done) begin
                        r_dwait <= 1'b0;
                        r_dsel <= r_dsel + 2'd1;
                        unique case (r_dsel)
                            2'd0: r_out.white_fraction <= w_quot[16:0];
                            2'd1: r_out.mean_row <= w_quot[20:0];
                            2'd2: r_out.second_moment <= w_quot[20:0];
                            default: r_out.black_ratio <= w_quot[16:0];
                        endcase
                    end
                end
                ST_OUT: begin
                    r_out.top_black_row <= r_top;
                    r_out.bottom_black_row <= r_bot;
                    r_out.top_gradient <= grad(
                        r_lft[r_top] != r_rgt[r_top],
                        ((r_top != 6'd0) ? r_col[r_top - 6'd1] : 1'b0) !=
                        ((7'(r_top) + 7'd1 < r_rows) ? r_col[r_top + 6'd1] : 1'b0));
                    r_out.bottom_gradient <= grad(
                        r_lft[r_bot] != r_rgt[r_bot],
                        ((r_bot != 6'd0) ? r_col[r_bot - 6'd1] : 1'b0) !=
                        ((7'(r_bot) + 7'd1 < r_rows) ? r_col[r_bot + 6'd1] : 1'b0));
                    r_out.transitions <= r_trans;
                    r_out.last_result <= r_last;
                    r_ovalid <= 1'b1;
                    if (r_last) begin
                        r_pend <= 1'b0; r_have <= 1'b0;
                        r_left <= '0; r_held <= '0;
                    end else if (r_newlast) begin
                        // held result done; the last column still waits
                        r_left <= r_held; r_have <= 1'b0;
                    end else begin
                        r_left <= r_held; r_held <= r_new; r_pend <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    `CHF_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE)
    `CHF_ASSERT_NXT(a_out_from_seq, i_clk, i_rst_n, r_state == ST_OUT, o_out_valid)
    `CHF_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_in_ready)
    `CHF_ASSERT_IMP(a_span_order, i_clk, i_rst_n, r_state == ST_DIV, r_top <= r_bot)
endmodule

// File: rtl/chf_divider.sv
// Restoring serial divider, one quotient bit a cycle
module chf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chf_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [40:0]       o_quot
);
    import chf_pkg::*;

    logic [40:0] r_quot;
    logic [13:0] r_rem;
    logic [12:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [13:0] w_shift;
    logic [14:0] w_diff;

    assign w_shift = {r_rem[12:0], r_quot[40]};
    assign w_diff  = {1'b0, w_shift} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 6'd40;
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[14]) begin
                r_rem  <= w_diff[13:0];
                r_quot <= {r_quot[39:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[39:0], 1'b0};
            end
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_cnt <= r_cnt - 6'd1;
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
